// ===== sv/ghif_pkg.sv =====
// Shared types and constants for the gyro heading integrator with failsafe monitors.
// Used by gyro_heading_integrator_failsafe_core; depends on nothing else.
package ghif_pkg;

    // Field widths of one item and one result.
    localparam int unsigned OP_W      = 3;
    localparam int unsigned AXIS_W    = 16;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned HOFS_W    = 41;
    localparam int unsigned RATE_W    = 17;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned LIMIT16_W = 16;
    localparam int unsigned ANGLIM_W  = 40;
    localparam int unsigned PRODUCT_W = RATE_W + ELAPSED_W + 1;

    // Stream packing.
    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned S_TUSER_W = OP_W;
    localparam int unsigned M_TDATA_W = 104;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;

    // Register values after reset.
    localparam logic [LIMIT16_W-1:0] RATE_LIMIT_RST  = 16'h8000;
    localparam logic [ANGLIM_W-1:0]  ANGLE_LIMIT_RST = 40'hFF_FFFF_FFFF;
    localparam logic [LIMIT16_W-1:0] ACCEL_LIMIT_RST = 16'h8000;

    // Item operations carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE        = 3'd0,
        OP_CLEAR_HEADING = 3'd1,
        OP_ADD_HEADING   = 3'd2,
        OP_CLEAR_FORWARD = 3'd3,
        OP_CLEAR_RADIAL  = 3'd4
    } op_t;

    // Configuration register indexes (byte address is eight times the index).
    typedef enum logic [1:0] {
        REG_GYRO_OFFSET = 2'd0,
        REG_RATE_LIMIT  = 2'd1,
        REG_ANGLE_LIMIT = 2'd2,
        REG_ACCEL_LIMIT = 2'd3
    } reg_idx_t;

endpackage

// ===== sv/gyro_heading_integrator_failsafe_core.sv =====
// Gyro heading integrator with over-rate angle, accel peak and accel limit monitors.
// An accepted item passes the input register, then the result register, which offers its result.
// One item per cycle if m_tready is high; critical path: 17x16 turn multiply, 64-bit subtract.
// The heading, flags and peaks are the state registers themselves, updated as the result loads.
// Reset (aresetn low, synchronous) clears all state and valid flags and loads register defaults.
// Depends on ghif_pkg.
module gyro_heading_integrator_failsafe_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, low bit up: accel_radial[15:0], accel_forward[15:0], gyro_rate[15:0],
    // elapsed_us[15:0], heading_offset[40:0], seven zero bits
    input  logic [ghif_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: operation[2:0]
    input  logic [ghif_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, low bit up: heading[63:0], over_rate, over_angle, over_accel,
    // peak_forward[15:0], peak_radial[15:0], five zero bits
    output logic [ghif_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ghif_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ghif_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ghif_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Configuration registers
    logic [ghif_pkg::LIMIT16_W-1:0] gyro_offset_reg;
    logic [ghif_pkg::LIMIT16_W-1:0] rate_limit_reg;
    logic [ghif_pkg::ANGLIM_W-1:0]  angle_limit_reg;
    logic [ghif_pkg::LIMIT16_W-1:0] accel_limit_reg;

    // Input register
    logic                           in_valid_reg;
    logic [ghif_pkg::OP_W-1:0]      in_op_reg;
    logic [ghif_pkg::AXIS_W-1:0]    in_radial_reg;
    logic [ghif_pkg::AXIS_W-1:0]    in_forward_reg;
    logic [ghif_pkg::AXIS_W-1:0]    in_gyro_reg;
    logic [ghif_pkg::ELAPSED_W-1:0] in_elapsed_reg;
    logic [ghif_pkg::HOFS_W-1:0]    in_hofs_reg;

    // State registers, which also form the result register
    logic                           out_valid_reg;
    logic                           over_accel_reg;
    logic [ghif_pkg::ACC_W-1:0]     heading_acc_reg;
    logic [ghif_pkg::RATE_W-1:0]    prev_rate_reg;
    logic [ghif_pkg::ACC_W-1:0]     over_rate_angle_reg;
    logic                           over_rate_flag_reg;
    logic [ghif_pkg::AXIS_W-1:0]    forward_peak_reg;
    logic [ghif_pkg::AXIS_W-1:0]    radial_peak_reg;

    // Next values
    logic                           over_accel_next;
    logic [ghif_pkg::ACC_W-1:0]     heading_acc_next;
    logic [ghif_pkg::RATE_W-1:0]    prev_rate_next;
    logic [ghif_pkg::ACC_W-1:0]     over_rate_angle_next;
    logic                           over_rate_flag_next;
    logic [ghif_pkg::AXIS_W-1:0]    forward_peak_next;
    logic [ghif_pkg::AXIS_W-1:0]    radial_peak_next;

    // Datapath intermediates
    logic                           advance;
    logic                           cfg_write;
    logic [1:0]                     cfg_index;
    logic [ghif_pkg::AXIS_W-1:0]    radial_mag;
    logic [ghif_pkg::AXIS_W-1:0]    forward_mag;
    logic [ghif_pkg::RATE_W-1:0]    rate_mag;
    logic signed [ghif_pkg::PRODUCT_W-1:0] turn_prod;
    logic [ghif_pkg::ACC_W-1:0]     turn;
    logic [ghif_pkg::ACC_W-1:0]     angle_mag;
    logic                           over_angle;

    // Handshake: the input register refills whenever its item moves on.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // Configuration write and read decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[ghif_pkg::APB_ADDR_W-1:3];

    always_comb begin
        case (cfg_index)
            ghif_pkg::REG_GYRO_OFFSET: prdata = {48'd0, gyro_offset_reg};
            ghif_pkg::REG_RATE_LIMIT:  prdata = {48'd0, rate_limit_reg};
            ghif_pkg::REG_ANGLE_LIMIT: prdata = {24'd0, angle_limit_reg};
            ghif_pkg::REG_ACCEL_LIMIT: prdata = {48'd0, accel_limit_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_offset_reg <= '0;
            rate_limit_reg  <= ghif_pkg::RATE_LIMIT_RST;
            angle_limit_reg <= ghif_pkg::ANGLE_LIMIT_RST;
            accel_limit_reg <= ghif_pkg::ACCEL_LIMIT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                ghif_pkg::REG_GYRO_OFFSET: gyro_offset_reg <= pwdata[15:0];
                ghif_pkg::REG_RATE_LIMIT:  rate_limit_reg  <= pwdata[15:0];
                ghif_pkg::REG_ANGLE_LIMIT: angle_limit_reg <= pwdata[39:0];
                ghif_pkg::REG_ACCEL_LIMIT: accel_limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg      <= s_tuser;
            in_radial_reg  <= s_tdata[15:0];
            in_forward_reg <= s_tdata[31:16];
            in_gyro_reg    <= s_tdata[47:32];
            in_elapsed_reg <= s_tdata[63:48];
            in_hofs_reg    <= s_tdata[104:64];
        end
    end

    // Magnitudes of the accel axes and of the stored corrected rate.
    assign radial_mag  = in_radial_reg[15]  ? (16'd0 - in_radial_reg)  : in_radial_reg;
    assign forward_mag = in_forward_reg[15] ? (16'd0 - in_forward_reg) : in_forward_reg;
    assign rate_mag    = prev_rate_reg[16]  ? (17'd0 - prev_rate_reg)  : prev_rate_reg;

    // Turn during the elapsed interval, using the previous corrected rate.
    assign turn_prod = $signed(prev_rate_reg) * $signed({1'b0, in_elapsed_reg});
    assign turn      = {{(ghif_pkg::ACC_W-ghif_pkg::PRODUCT_W){turn_prod[ghif_pkg::PRODUCT_W-1]}},
                        turn_prod};

    // Next state for the item in the input register.
    always_comb begin
        over_accel_next      = 1'b0;
        heading_acc_next     = heading_acc_reg;
        prev_rate_next       = prev_rate_reg;
        over_rate_angle_next = over_rate_angle_reg;
        over_rate_flag_next  = over_rate_flag_reg;
        forward_peak_next    = forward_peak_reg;
        radial_peak_next     = radial_peak_reg;
        case (in_op_reg)
            ghif_pkg::OP_SAMPLE: begin
                over_accel_next = (radial_mag > accel_limit_reg) ||
                                  (forward_mag > accel_limit_reg);
                if (radial_mag > radial_peak_reg) begin
                    radial_peak_next = radial_mag;
                end
                if (forward_mag > forward_peak_reg) begin
                    forward_peak_next = forward_mag;
                end
                heading_acc_next = heading_acc_reg - turn;
                if (rate_mag > {1'b0, rate_limit_reg}) begin
                    over_rate_flag_next  = 1'b1;
                    over_rate_angle_next = over_rate_angle_reg - turn;
                end else begin
                    over_rate_flag_next  = 1'b0;
                    over_rate_angle_next = '0;
                end
                prev_rate_next = {in_gyro_reg[15], in_gyro_reg} -
                                 {gyro_offset_reg[15], gyro_offset_reg};
            end
            ghif_pkg::OP_CLEAR_HEADING: begin
                heading_acc_next = '0;
            end
            ghif_pkg::OP_ADD_HEADING: begin
                heading_acc_next = heading_acc_reg +
                    {{(ghif_pkg::ACC_W-ghif_pkg::HOFS_W){in_hofs_reg[ghif_pkg::HOFS_W-1]}},
                     in_hofs_reg};
            end
            ghif_pkg::OP_CLEAR_FORWARD: begin
                forward_peak_next = '0;
            end
            ghif_pkg::OP_CLEAR_RADIAL: begin
                radial_peak_next = '0;
            end
            default: ;
        endcase
    end

    // State and result register: loads exactly when an item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg       <= 1'b0;
            over_accel_reg      <= 1'b0;
            heading_acc_reg     <= '0;
            prev_rate_reg       <= '0;
            over_rate_angle_reg <= '0;
            over_rate_flag_reg  <= 1'b0;
            forward_peak_reg    <= '0;
            radial_peak_reg     <= '0;
        end else begin
            if (advance) begin
                out_valid_reg       <= 1'b1;
                over_accel_reg      <= over_accel_next;
                heading_acc_reg     <= heading_acc_next;
                prev_rate_reg       <= prev_rate_next;
                over_rate_angle_reg <= over_rate_angle_next;
                over_rate_flag_reg  <= over_rate_flag_next;
                forward_peak_reg    <= forward_peak_next;
                radial_peak_reg     <= radial_peak_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The angle flag follows the stored angle, which always matches the offered result.
    assign angle_mag  = over_rate_angle_reg[63] ? (64'd0 - over_rate_angle_reg)
                                                : over_rate_angle_reg;
    assign over_angle = angle_mag > {24'd0, angle_limit_reg};

    assign m_tdata = {5'd0, radial_peak_reg, forward_peak_reg, over_accel_reg,
                      over_angle, over_rate_flag_reg, heading_acc_reg};

    // The offered result must not change under it while it waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> $stable(heading_acc_reg) && $stable(over_rate_angle_reg))
        else $error("state changed while a result was stalled");

    // A cleared over-rate flag always comes with a zero accumulated angle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !over_rate_flag_reg |-> over_rate_angle_reg == '0)
        else $error("over-rate angle nonzero with flag clear");

    // Only a sample item can raise the accel flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg != ghif_pkg::OP_SAMPLE |=> !over_accel_reg)
        else $error("accel flag raised by a non-sample item");

    // Backpressure reaches the input only when the input register holds an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with room to accept");

endmodule
